@@ design/jmcs_pkg.sv @@
// Shared types, codes and helpers for the joint mode crossfade safety unit.
`timescale 1ns / 1ps
package jmcs_pkg;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_SET_MODE = 3'd1,
    OP_WRITE_LIMIT = 3'd2,
    OP_STOP = 3'd3,
    OP_EMIT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    LIM_TORQUE = 2'd0,
    LIM_CURRENT = 2'd1,
    LIM_DRIVE = 2'd2
  } limit_kind_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BUSY = 2'd1,
    ST_SAME = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLEND,
    S_CHECK,
    S_REPLY,
    S_EMIT
  } state_e;

  localparam int unsigned ResultMax = 32;

  // Crossfade length in samples; a power of two so the blend divides by a shift
  localparam int unsigned FadeSteps = 1024;

  typedef struct packed {
    logic [2:0] operation;
    logic [4:0] joint;
    logic [1:0] mode;
    logic [1:0] limit_kind;
    logic [30:0] limit_value;
    logic signed [31:0] ctrl_zero;
    logic signed [31:0] ctrl_one;
    logic signed [31:0] ctrl_two;
    logic signed [31:0] ctrl_three;
    logic signed [31:0] torque_est;
    logic signed [31:0] torque_pred;
    logic signed [31:0] current_meas;
  } in_t;

  typedef struct packed {
    logic kind;
    logic [4:0] joint_out;
    logic signed [31:0] drive_value;
    logic [1:0] status;
    logic stopped;
    logic last;
  } out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic do_blend;
    logic do_check;
    logic do_setmode;
    logic do_limit;
    logic do_stop;
    logic emit_start;
    logic emit_next;
    logic out_load_reply;
    logic out_load_emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic joint_ok;
    logic mode_ok;
    logic has_mode;
    logic emit_done;
  } stat_t;

  // Absolute value of a 32-bit signed number, exact
  function automatic logic [32:0] mag32(logic [31:0] v);
    logic [32:0] e;
    e = {v[31], v};
    return v[31] ? (33'd0 - e) : e;
  endfunction

endpackage

@@ design/jmcs_datapath.sv @@
// Datapath: per-joint state, crossfade arithmetic, limit checks and result register.
`timescale 1ns / 1ps
module jmcs_datapath
  import jmcs_pkg::*;
#(
  parameter int unsigned JOINTS = 32,
  parameter int unsigned MODES = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_i,
  input  cmd_t cmd_i,
  output stat_t stat_o,
  output out_t res_o
);
  localparam int unsigned FadeW = $clog2(FadeSteps + 1);
  localparam int unsigned FadeSh = $clog2(FadeSteps);
  localparam int unsigned EmitN = (JOINTS < ResultMax) ? JOINTS : ResultMax;
  localparam int unsigned JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int unsigned NumW = 32 + FadeW + 1;

  logic             valid_q [JOINTS];
  logic [1:0]       now_q [JOINTS];
  logic [1:0]       before_q [JOINTS];
  logic [FadeW-1:0] fade_q [JOINTS];
  logic [31:0]      drive_q [JOINTS];
  logic [30:0]      tlim_q [JOINTS];
  logic [30:0]      clim_q [JOINTS];
  logic [30:0]      dlim_q [JOINTS];
  logic             stop_q;
  logic             chk2_q;

  in_t              item_q;
  logic [JW-1:0]    jx_q;
  logic [5:0]       emit_q;
  logic signed [NumW-1:0] prod_a_q, prod_b_q;
  out_t             res_q;

  logic [4:0]  jfull;
  logic [JW-1:0] jx_d;
  assign jfull = in_i.joint;
  assign jx_d = JW'(jfull);

  function automatic logic signed [31:0] pick(in_t it, logic [1:0] m);
    unique case (m)
      2'd0: return it.ctrl_zero;
      2'd1: return it.ctrl_one;
      2'd2: return it.ctrl_two;
      default: return it.ctrl_three;
    endcase
  endfunction

  // Blend sum, round to nearest with ties away from zero
  logic signed [NumW-1:0] num;
  logic [NumW-1:0] mag, qmag;
  logic signed [31:0] blended;
  always_comb begin
    num = prod_a_q + prod_b_q;
    mag = num[NumW-1] ? (~num + NumW'(1)) : num;
    qmag = (mag + NumW'(FadeSteps / 2)) >> FadeSh;
    blended = num[NumW-1] ? 32'(~qmag + NumW'(1)) : 32'(qmag);
  end

  logic signed [31:0] cur_v, prev_v;
  logic [FadeW-1:0] c_v;
  always_comb begin
    cur_v = pick(item_q, now_q[jx_q]);
    prev_v = pick(item_q, before_q[jx_q]);
    c_v = fade_q[jx_q];
  end

  // Status to controller
  always_comb begin
    stat_o.joint_ok = 32'(jfull) < JOINTS;
    stat_o.mode_ok = 32'(in_i.mode) < MODES;
    stat_o.has_mode = valid_q[jx_d];
    stat_o.emit_done = 32'(emit_q) == EmitN - 1;
  end

  // Capture item and multiplier products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
      jx_q <= jx_d;
    end
    if (cmd_i.do_blend) begin
      prod_a_q <= NumW'(prev_v) * $signed({1'b0, c_v});
      prod_b_q <= NumW'(cur_v) * $signed({1'b0, FadeW'(FadeSteps) - c_v});
    end
  end

  // Per-joint state updates
  logic viol;
  always_comb begin
    viol = mag32(item_q.torque_est) > {2'b0, tlim_q[jx_q]} ||
           mag32(item_q.torque_pred) > {2'b0, tlim_q[jx_q]} ||
           mag32(item_q.current_meas) > {2'b0, clim_q[jx_q]} ||
           mag32(drive_q[jx_q]) > {2'b0, dlim_q[jx_q]};
  end

  status_e st;
  always_comb begin
    if (fade_q[jx_q] != '0) st = ST_BUSY;
    else if (valid_q[jx_q] && now_q[jx_q] == item_q.mode) st = ST_SAME;
    else st = ST_ACCEPTED;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < JOINTS; i++) begin
        valid_q[i] <= 1'b0;
        now_q[i] <= '0;
        before_q[i] <= '0;
        fade_q[i] <= '0;
        drive_q[i] <= '0;
        tlim_q[i] <= '1;
        clim_q[i] <= '1;
        dlim_q[i] <= '1;
      end
      stop_q <= 1'b0;
    end else begin
      // Drive update for a sample of a joint with a mode
      if (cmd_i.do_blend && c_v == '0) drive_q[jx_q] <= cur_v;
      if (cmd_i.do_check && fade_q[jx_q] != '0) begin
        drive_q[jx_q] <= blended;
        fade_q[jx_q] <= fade_q[jx_q] - FadeW'(1);
      end
      if (cmd_i.do_check && fade_q[jx_q] == '0 && viol) stop_q <= 1'b1;
      // A fading sample checks its limits in the next cycle, after the drive is written
      if (chk2_q && viol) stop_q <= 1'b1;
      if (cmd_i.do_setmode && st == ST_ACCEPTED) begin
        if (!valid_q[jx_q]) begin
          before_q[jx_q] <= item_q.mode;
          valid_q[jx_q] <= 1'b1;
        end else begin
          fade_q[jx_q] <= FadeW'(FadeSteps);
          before_q[jx_q] <= now_q[jx_q];
        end
        now_q[jx_q] <= item_q.mode;
      end
      if (cmd_i.do_limit) begin
        unique case (item_q.limit_kind)
          LIM_TORQUE: tlim_q[jx_q] <= item_q.limit_value;
          LIM_CURRENT: clim_q[jx_q] <= item_q.limit_value;
          LIM_DRIVE: dlim_q[jx_q] <= item_q.limit_value;
          default: ;
        endcase
      end
      if (cmd_i.do_stop) stop_q <= 1'b1;
    end
  end

  // Flag the delayed limit check of a fading sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chk2_q <= 1'b0;
    else chk2_q <= cmd_i.do_check && fade_q[jx_q] != '0;
  end

  // Emit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emit_q <= '0;
    else if (cmd_i.emit_start) emit_q <= '0;
    else if (cmd_i.emit_next) emit_q <= emit_q + 6'd1;
  end

  // Result register
  logic [JW-1:0] ex;
  assign ex = JW'(emit_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_reply) begin
      res_q.kind <= 1'b0;
      res_q.joint_out <= item_q.joint;
      res_q.drive_value <= '0;
      res_q.status <= st;
      res_q.stopped <= stop_q;
      res_q.last <= 1'b0;
    end else if (cmd_i.out_load_emit) begin
      res_q.kind <= 1'b1;
      res_q.joint_out <= emit_q[4:0];
      res_q.drive_value <= stop_q ? '0 : drive_q[ex];
      res_q.status <= ST_ACCEPTED;
      res_q.stopped <= stop_q;
      res_q.last <= stat_o.emit_done;
    end
  end
  assign res_o = res_q;
endmodule

@@ design/jmcs_ctrl.sv @@
// Controller: sequences one transaction at a time through the datapath.
`timescale 1ns / 1ps
module jmcs_ctrl
  import jmcs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic [2:0] op_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;
  logic ov_q, ov_d;
  logic [2:0] op_q, op_d;
  logic sampled_q, sampled_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
      op_q <= OP_SAMPLE;
      sampled_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      op_q <= op_d;
      sampled_q <= sampled_d;
    end
  end

  logic out_free;
  assign out_free = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    sampled_d = sampled_q;
    cmd_o = '0;
    ov_d = ov_q && out_stall_i;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d = op_i;
          priority if (op_i == OP_SAMPLE && stat_i.joint_ok) begin
            sampled_d = stat_i.has_mode;
            state_d = S_BLEND;
          end else if (op_i == OP_SET_MODE && stat_i.joint_ok && stat_i.mode_ok) begin
            state_d = S_REPLY;
          end else if (op_i == OP_WRITE_LIMIT && stat_i.joint_ok) begin
            state_d = S_CHECK;
          end else if (op_i == OP_STOP) begin
            state_d = S_CHECK;
          end else if (op_i == OP_EMIT) begin
            cmd_o.emit_start = 1'b1;
            state_d = S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_BLEND: begin
        cmd_o.do_blend = sampled_q;
        op_d = OP_SAMPLE;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (op_q == OP_SAMPLE) begin
          cmd_o.do_check = 1'b1;
          state_d = S_IDLE;
        end else if (op_q == OP_WRITE_LIMIT) begin
          cmd_o.do_limit = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.do_stop = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          cmd_o.out_load_reply = 1'b1;
          cmd_o.do_setmode = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.out_load_emit = 1'b1;
          cmd_o.emit_next = 1'b1;
          ov_d = 1'b1;
          if (stat_i.emit_done) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid only rises on a load command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.out_load_reply || cmd_o.out_load_emit))
    else $error("result valid without load");
  // Items are taken only in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == S_IDLE)
    else $error("input accepted while busy");
  // A blend step is always followed by its check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BLEND |=> state_q == S_CHECK)
    else $error("blend not followed by check");
endmodule

@@ design/joint_mode_crossfade_safety_unit.sv @@
// Top level: joint mode crossfade with safety latch, controller plus datapath.
//   channel | dir | handshake           | payload
//   in      | in  | in_valid_i/stall_o  | in_t
//   out     | out | out_valid_o/stall_i | out_t
// Sample: accept, multiplier stage, state write; the limit check of
// a fading sample runs in the following cycle, overlapped with the next accept.
// Set mode: accept, then reply once the output is free; limit write and stop: accept, then write.
// Emit: accept, then one result per joint, paced by the single result register.
// Reset clears all per-joint state and the stop latch.
// A stalled output holds the controller in its reply or emit step.
`timescale 1ns / 1ps
module joint_mode_crossfade_safety_unit
  import jmcs_pkg::*;
#(
  parameter int unsigned JOINTS = 32,
  parameter int unsigned MODES = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);
  cmd_t cmd;
  stat_t stat;

  jmcs_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i),
    .op_i(in_data_i.operation), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .stat_i(stat), .cmd_o(cmd)
  );

  jmcs_datapath #(.JOINTS(JOINTS), .MODES(MODES)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_data_i), .cmd_i(cmd),
    .stat_o(stat), .res_o(out_data_o)
  );
endmodule

@@ tb/tb_joint_mode_crossfade_safety_unit.sv @@
// Self-checking testbench for the joint mode crossfade safety unit.
`timescale 1ns / 1ps
module tb_joint_mode_crossfade_safety_unit;
  import jmcs_pkg::*;

  localparam int NJ = 32;
  localparam int FADE = 1024;
  localparam longint LIM_MAX = 64'h7FFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_WAIT = 50;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  joint_mode_crossfade_safety_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  // Shadow copy of the per-joint drive state
  bit          has_mode[NJ];
  logic [1:0]  cur_mode[NJ];
  logic [1:0]  prev_mode[NJ];
  int unsigned fade_left[NJ];
  logic [31:0] drive_mem[NJ];
  longint      torque_lim[NJ];
  longint      current_lim[NJ];
  longint      drive_lim[NJ];
  bit          estop;

  out_t pending_results[$];
  int   errors = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   cycles = 0;
  bit   quiet_in = 0;
  bit   quiet_out = 0;
  bit   long_hold_req = 0;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;
  row_t stim_rows[$];

  // Generate the clock
  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("joint_mode_crossfade_safety_unit: mismatch");
      $finish;
    end
  end

  function automatic longint abs32(logic [31:0] v);
    longint s;
    s = longint'(signed'(v));
    return s < 0 ? -s : s;
  endfunction

  function automatic longint ctrl_of(in_t x, logic [1:0] m);
    case (m)
      2'd0: return longint'(x.ctrl_zero);
      2'd1: return longint'(x.ctrl_one);
      2'd2: return longint'(x.ctrl_two);
      default: return longint'(x.ctrl_three);
    endcase
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < NJ; i++) begin
      has_mode[i] = 0;
      cur_mode[i] = 0;
      prev_mode[i] = 0;
      fade_left[i] = 0;
      drive_mem[i] = 0;
      torque_lim[i] = LIM_MAX;
      current_lim[i] = LIM_MAX;
      drive_lim[i] = LIM_MAX;
    end
    estop = 0;
  endfunction

  // Advance the shadow state by one transaction and return its drive results
  function automatic void drive_update(in_t x, ref out_t res[$]);
    int j;
    longint cur, prev, num, mag, q, d;
    out_t r;
    j = x.joint;
    res.delete();
    case (x.operation)
      OP_SAMPLE: begin
        if (has_mode[j]) begin
          cur = ctrl_of(x, cur_mode[j]);
          d = cur;
          if (fade_left[j] != 0) begin
            prev = ctrl_of(x, prev_mode[j]);
            num = prev * fade_left[j] + cur * (FADE - fade_left[j]);
            mag = num < 0 ? -num : num;
            q = (mag + FADE / 2) / FADE;
            d = num < 0 ? -q : q;
            fade_left[j]--;
          end
          drive_mem[j] = d[31:0];
        end
        if (abs32(x.torque_est) > torque_lim[j] || abs32(x.torque_pred) > torque_lim[j] ||
            abs32(x.current_meas) > current_lim[j] || abs32(drive_mem[j]) > drive_lim[j])
          estop = 1;
      end
      OP_SET_MODE: begin
        r = '0;
        r.joint_out = x.joint;
        if (fade_left[j] != 0) r.status = ST_BUSY;
        else if (has_mode[j] && cur_mode[j] == x.mode) r.status = ST_SAME;
        else begin
          if (!has_mode[j]) begin
            prev_mode[j] = x.mode;
            has_mode[j] = 1;
          end else begin
            fade_left[j] = FADE;
            prev_mode[j] = cur_mode[j];
          end
          cur_mode[j] = x.mode;
          r.status = ST_ACCEPTED;
        end
        r.stopped = estop;
        res.insert(res.size(), r);
      end
      OP_WRITE_LIMIT: begin
        case (x.limit_kind)
          LIM_TORQUE: torque_lim[j] = x.limit_value;
          LIM_CURRENT: current_lim[j] = x.limit_value;
          LIM_DRIVE: drive_lim[j] = x.limit_value;
          default: ;
        endcase
      end
      OP_STOP: estop = 1;
      OP_EMIT: begin
        for (int i = 0; i < NJ; i++) begin
          r = '0;
          r.kind = 1;
          r.joint_out = 5'(i);
          r.drive_value = estop ? 32'd0 : drive_mem[i];
          r.stopped = estop;
          r.last = (i == NJ - 1);
          res.insert(res.size(), r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Offer one transaction and hold it until accepted; typed rows override the prediction
  task automatic send(in_t x, bit typed = 0, out_t want = '0);
    int g;
    out_t res[$];
    g = pick_gap(quiet_in);
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= x;
    do @(negedge clk_i); while (in_stall_o);
    drive_update(x, res);
    if (typed) begin
      if (res.size() != 1) report("typed row result count", res.size(), 1);
      res.delete();
      res.insert(0, want);
    end
    foreach (res[k]) pending_results.insert(pending_results.size(), res[k]);
    items_sent++;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand32(bit safe);
    logic [31:0] v;
    case ($urandom_range(7))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = 32'd0;
      3: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    if (safe && v == 32'h8000_0000) v = 32'h8000_0001;
    return v;
  endfunction

  // Random transaction: safe items never trip the stop latch
  function automatic in_t rand_item(bit safe);
    in_t x;
    int r;
    x = '0;
    r = $urandom_range(99);
    if (r < 55) x.operation = OP_SAMPLE;
    else if (r < 77) x.operation = OP_SET_MODE;
    else if (r < 86) x.operation = OP_WRITE_LIMIT;
    else if (r < 92) x.operation = OP_EMIT;
    else if (r < 96) x.operation = safe ? OP_SAMPLE : OP_STOP;
    else x.operation = 3'($urandom_range(7, 5));
    x.joint = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom);
    x.mode = 2'($urandom);
    x.limit_kind = 2'($urandom);
    x.limit_value = safe ? 31'h7FFF_FFFF : 31'(rand32(0));
    x.ctrl_zero = rand32(safe);
    x.ctrl_one = rand32(safe);
    x.ctrl_two = rand32(safe);
    x.ctrl_three = rand32(safe);
    x.torque_est = rand32(safe);
    x.torque_pred = rand32(safe);
    x.current_meas = rand32(safe);
    return x;
  endfunction

  function automatic in_t mk(op_e op, int j, int m = 0);
    in_t x;
    x = '0;
    x.operation = op;
    x.joint = 5'(j);
    x.mode = 2'(m);
    return x;
  endfunction

  function automatic out_t reply(int j, status_e s);
    out_t r;
    r = '0;
    r.joint_out = 5'(j);
    r.status = s;
    return r;
  endfunction

  function automatic void add_row(in_t x, bit typed = 0, out_t want = '0);
    row_t w;
    w.item = x;
    w.typed = typed;
    w.want = want;
    stim_rows.insert(stim_rows.size(), w);
  endfunction

  // Check each result transaction against the oldest expectation
  initial begin
    out_t got, want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = out_data_o;
        results_seen++;
        if (pending_results.size() == 0) begin
          report("unexpected result, joint", got.joint_out, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind) report("kind", got.kind, want.kind);
          if (got.joint_out !== want.joint_out)
            report("joint_out", got.joint_out, want.joint_out);
          if (got.drive_value !== want.drive_value)
            report("drive_value", got.drive_value, want.drive_value);
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.stopped !== want.stopped) report("stopped", got.stopped, want.stopped);
          if (got.last !== want.last) report("last", got.last, want.last);
        end
      end
    end
  end

  // Drive receiver backpressure, including one long hold-off
  initial begin
    bit held;
    held = 0;
    out_stall_i = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !held) begin
        held = 1;
        out_stall_i <= 1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 0;
      end else if (quiet_out) begin
        out_stall_i <= 0;
      end else if ($urandom_range(99) < 3) begin
        out_stall_i <= 1;
        repeat ($urandom_range(25, 8)) @(posedge clk_i);
        out_stall_i <= 0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 25);
      end
    end
  end

  // Main stimulus
  initial begin
    in_t x;
    in_valid_i = 0;
    in_data_i = '0;
    rst_ni = 0;
    reset_shadow();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed rows that leave the stop latch clear
    add_row(mk(OP_EMIT, 0));
    add_row(mk(OP_SET_MODE, 0, 2), 1, reply(0, ST_ACCEPTED));
    add_row(mk(OP_SET_MODE, 0, 2), 1, reply(0, ST_SAME));
    add_row(mk(OP_SET_MODE, 0, 3), 1, reply(0, ST_ACCEPTED));
    add_row(mk(OP_SET_MODE, 0, 1), 1, reply(0, ST_BUSY));
    x = mk(OP_SAMPLE, 0);
    x.ctrl_two = 32'h7FFF_FFFF;
    x.ctrl_three = 32'h8000_0001;
    add_row(x);
    x = mk(OP_SAMPLE, 31);
    x.ctrl_zero = 32'h1234_5678;
    add_row(x);
    add_row(mk(OP_SET_MODE, 31, 0), 1, reply(31, ST_ACCEPTED));
    x = mk(OP_SAMPLE, 31);
    x.ctrl_zero = 32'h7FFF_FFFF;
    x.torque_est = 32'h7FFF_FFFF;
    x.torque_pred = 32'h8000_0001;
    x.current_meas = 32'hFFFF_FFFF;
    add_row(x);
    x = mk(OP_WRITE_LIMIT, 5);
    x.limit_kind = 2'd3;
    x.limit_value = '0;
    add_row(x);
    x = mk(OP_WRITE_LIMIT, 5);
    x.limit_kind = LIM_TORQUE;
    x.limit_value = 31'h7FFF_FFFF;
    add_row(x);
    add_row(mk(op_e'(3'd5), 2));
    add_row(mk(op_e'(3'd6), 2));
    add_row(mk(op_e'(3'd7), 2));
    add_row(mk(OP_SET_MODE, 3, 3), 1, reply(3, ST_ACCEPTED));
    add_row(mk(OP_EMIT, 0));
    foreach (stim_rows[i]) send(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);

    // Run part of one crossfade back to back on a single joint
    quiet_in = 1;
    send(mk(OP_SET_MODE, 1, 0));
    send(mk(OP_SET_MODE, 1, 2));
    for (int i = 0; i < 60; i++) begin
      x = rand_item(1);
      x.operation = (i % 200 == 7) ? OP_SET_MODE : OP_SAMPLE;
      x.joint = 1;
      send(x);
    end
    send(mk(OP_EMIT, 0));
    quiet_in = 0;

    // Random traffic with the latch clear; the output holds off while the input fills
    for (int i = 0; i < 130; i++) begin
      if (i == 40) long_hold_req = 1;
      if (i == 90) begin
        in_valid_i <= 0;
        wait (pending_results.size() == 0);
        @(posedge clk_i);
      end
      if (i == 100) quiet_out = 1;
      if (i == 120) quiet_out = 0;
      if (i == 20) quiet_in = 1;
      if (i == 35) quiet_in = 0;
      x = rand_item(1);
      if (i == 30) x.operation = OP_EMIT;
      send(x);
    end

    // Directed rows that trip the latch
    x = mk(OP_WRITE_LIMIT, 7);
    x.limit_kind = LIM_TORQUE;
    x.limit_value = '0;
    send(x);
    x = mk(OP_SAMPLE, 7);
    x.torque_est = 32'd1;
    send(x);
    send(mk(OP_SET_MODE, 7, 1));
    send(mk(OP_STOP, 0));
    x = mk(OP_SAMPLE, 8);
    x.torque_pred = 32'h8000_0000;
    x.ctrl_zero = 32'h8000_0000;
    send(x);
    send(mk(OP_EMIT, 0));

    // Fully random traffic with the latch set
    for (int i = 0; i < 90; i++) send(rand_item(0));
    in_valid_i <= 0;

    // Drain outstanding results
    wait (pending_results.size() == 0);
    repeat (END_WAIT) @(posedge clk_i);
    $display("sent %0d transactions, checked %0d results, part of a crossfade back to back,",
             items_sent, results_seen);
    $display("stop latch tripped by limit, by external stop and by full-scale inputs");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("joint_mode_crossfade_safety_unit: match");
    end else begin
      $display("joint_mode_crossfade_safety_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/jmcs_pkg.sv
design/jmcs_datapath.sv
design/jmcs_ctrl.sv
design/joint_mode_crossfade_safety_unit.sv
tb/tb_joint_mode_crossfade_safety_unit.sv
